@@ rtl/core/sorted_open_interval_range_sum_macros.svh @@
// Assertion macros shared by the RTL
`ifndef SORTED_OPEN_INTERVAL_RANGE_SUM_MACROS_SVH
`define SORTED_OPEN_INTERVAL_RANGE_SUM_MACROS_SVH
// implication checked on every clock edge outside reset
`define SOIRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the next cycle
`define SOIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/soirs_pkg.sv @@
// ----------------------------------------------------------------------------
// soirs_pkg
// Types and constants for the open-interval range sum block.
// ----------------------------------------------------------------------------
package soirs_pkg;
  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned AddrW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned ValW = 32;
  localparam int unsigned SumW = 48;
  localparam int unsigned OutCntW = 11;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [ValW-1:0] load_value;
    logic signed [ValW-1:0] lower_bound;
    logic signed [ValW-1:0] upper_bound;
  } req_t;

  typedef struct packed {
    logic [OutCntW-1:0] match_count;
    logic signed [SumW-1:0] range_sum;
    logic load_dropped;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle, StHeapInit, StSiftRd, StSiftCmp, StSiftSwap, StExtract,
    StPrefix, StPrefixWr, StSearch, StSearchCmp, StSumRd, StSumWait, StOut
  } state_e;
endpackage

@@ rtl/core/soirs_if.sv @@
// ----------------------------------------------------------------------------
// soirs_req_if / soirs_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface soirs_req_if;
  logic valid;
  logic ready;
  soirs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface soirs_rsp_if;
  logic valid;
  logic ready;
  soirs_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sorted_open_interval_range_sum.sv @@
// ----------------------------------------------------------------------------
// sorted_open_interval_range_sum
// Open-interval count and sum over a loaded table of Q16.16 values.
// ----------------------------------------------------------------------------
// Usage: req_if carries one item per handshake: mode 0 appends load_value,
// mode 2 clears the table, mode 1 queries (lower_bound, upper_bound) and
// returns one item on rsp_if; mode 3 is ignored. Loads and clears are done
// on acceptance. The first query after a stored load or a clear heap-sorts
// the table in place and builds prefix sums; each sift level reads root
// and children, compares, and swaps with two writes. Every query then makes
// two binary searches of up to log2(N)+1 steps (one value memory read and
// compare per step), each closed by a final check, then two prefix reads,
// one subtract and the output load. The value memory has one port, shared
// by load, sort, prefix build and search. Requests are not taken while a
// query runs or while its result waits. Reset empties the table and clears
// the drop flag; memory contents stay undefined and no unwritten word is
// used in a result. A stalled receiver holds the result in its output
// register.
// ----------------------------------------------------------------------------
module sorted_open_interval_range_sum (
  input logic clk_i,
  input logic rst_ni,
  soirs_req_if.sink req_if,
  soirs_rsp_if.source rsp_if
);
  import soirs_pkg::*;

  logic signed [ValW-1:0] vmem [MaxEntries];
  logic signed [SumW-1:0] pmem [MaxEntries];

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic sorted_q, sorted_d, ovf_q, ovf_d;
  // sort bookkeeping
  logic [CntW-1:0] heap_i_q, heap_i_d;   // build / extract index
  logic [CntW-1:0] len_q, len_d;         // heap length
  logic [CntW-1:0] root_q, root_d, big_q, big_d;
  logic [1:0] sub_q, sub_d;              // read phase in sift; also step in extract and sum wait
  logic build_q, build_d;
  logic signed [ValW-1:0] rootv_q, rootv_d, bigv_q, bigv_d;
  logic signed [SumW-1:0] acc_q, acc_d;
  // search
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, start_q, start_d;
  logic second_q, second_d;
  logic signed [ValW-1:0] lb_q, lb_d, ub_q, ub_d;
  logic signed [SumW-1:0] psa_q, psa_d;
  logic [CntW-1:0] end_q, end_d;
  rsp_t rsp_q, rsp_d;
  logic rsp_v_q, rsp_v_d;

  // memory port
  logic v_we, p_we;
  logic [AddrW-1:0] v_addr, p_addr;
  logic signed [ValW-1:0] v_wd, v_rd;
  logic signed [SumW-1:0] p_wd, p_rd;
  logic [CntW-1:0] mid, child;

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_addr] <= v_wd;
    v_rd <= vmem[v_addr];
    if (p_we) pmem[p_addr] <= p_wd;
    p_rd <= pmem[p_addr];
  end

  assign req_if.ready = (state_q == StIdle) && !rsp_v_q;
  assign rsp_if.valid = rsp_v_q;
  assign rsp_if.data = rsp_q;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign child = {root_q[CntW-2:0], 1'b1};

  always_comb begin
    state_d = state_q; count_d = count_q; sorted_d = sorted_q; ovf_d = ovf_q;
    heap_i_d = heap_i_q; len_d = len_q; root_d = root_q; big_d = big_q;
    sub_d = sub_q; build_d = build_q; rootv_d = rootv_q; bigv_d = bigv_q;
    acc_d = acc_q; lo_d = lo_q; hi_d = hi_q; start_d = start_q;
    second_d = second_q; lb_d = lb_q; ub_d = ub_q; psa_d = psa_q;
    end_d = end_q; rsp_d = rsp_q; rsp_v_d = rsp_v_q;
    v_we = 1'b0; p_we = 1'b0; v_addr = '0; p_addr = '0;
    v_wd = '0; p_wd = '0;
    if (rsp_v_q && rsp_if.ready) rsp_v_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_if.valid && req_if.ready) begin
          unique case (req_if.data.mode)
            ModeLoad: begin
              if (count_q >= CntW'(MaxEntries)) ovf_d = 1'b1;
              else begin
                v_we = 1'b1; v_addr = count_q[AddrW-1:0];
                v_wd = req_if.data.load_value;
                count_d = count_q + 1'b1; sorted_d = 1'b0;
              end
            end
            ModeClear: begin
              count_d = '0; sorted_d = 1'b0; ovf_d = 1'b0;
            end
            ModeQuery: begin
              lb_d = req_if.data.lower_bound; ub_d = req_if.data.upper_bound;
              len_d = count_q; heap_i_d = count_q >> 1; build_d = 1'b1;
              acc_d = '0;
              state_d = sorted_q ? StSearch : StHeapInit;
              lo_d = '0; hi_d = count_q; second_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StHeapInit: begin
        // build phase: sift each inner node; then extract
        if (build_q) begin
          if (heap_i_q == '0) begin
            build_d = 1'b0; heap_i_d = count_q - 1'b1;
            state_d = StExtract;
          end else begin
            root_d = heap_i_q - 1'b1; heap_i_d = heap_i_q - 1'b1;
            sub_d = '0; state_d = StSiftRd;
          end
        end else state_d = StExtract;
      end
      StExtract: begin
        // swap a[0] with a[i], then sift root over length i
        if (count_q <= CntW'(1) || heap_i_q == '0) begin
          heap_i_d = '0; state_d = StPrefix; sub_d = '0;
        end else begin
          unique case (sub_q)
            2'd0: begin v_addr = '0; sub_d = 2'd1; end
            2'd1: begin
              rootv_d = v_rd; v_addr = heap_i_q[AddrW-1:0]; sub_d = 2'd2;
            end
            default: begin
              v_we = 1'b1; v_addr = '0; v_wd = v_rd; bigv_d = v_rd;
              sub_d = 2'd3;
              if (sub_q == 2'd3) begin
                v_addr = heap_i_q[AddrW-1:0]; v_wd = rootv_q;
                len_d = heap_i_q; heap_i_d = heap_i_q - 1'b1;
                root_d = '0; sub_d = '0; state_d = StSiftRd;
              end
            end
          endcase
        end
      end
      StSiftRd: begin
        // read root, left, right over successive cycles
        unique case (sub_q)
          2'd0: begin v_addr = root_q[AddrW-1:0]; sub_d = 2'd1; end
          2'd1: begin
            rootv_d = v_rd; big_d = root_q; bigv_d = v_rd;
            v_addr = child[AddrW-1:0];
            if (child < len_q) sub_d = 2'd2; else state_d = StSiftCmp;
          end
          2'd2: begin
            if (v_rd > bigv_q) begin big_d = child; bigv_d = v_rd; end
            v_addr = AddrW'(child + 1'b1);
            if (child + 1'b1 < len_q) sub_d = 2'd3; else state_d = StSiftCmp;
          end
          default: begin
            if (v_rd > bigv_q) begin big_d = child + 1'b1; bigv_d = v_rd; end
            state_d = StSiftCmp;
          end
        endcase
      end
      StSiftCmp: begin
        if (big_q == root_q) state_d = build_q ? StHeapInit : StExtract;
        else begin
          v_we = 1'b1; v_addr = root_q[AddrW-1:0]; v_wd = bigv_q;
          state_d = StSiftSwap;
        end
        sub_d = '0;
      end
      StSiftSwap: begin
        v_we = 1'b1; v_addr = big_q[AddrW-1:0]; v_wd = rootv_q;
        root_d = big_q; sub_d = '0; state_d = StSiftRd;
      end
      StPrefix: begin
        if (heap_i_q >= count_q) begin
          sorted_d = 1'b1; state_d = StSearch;
        end else begin
          v_addr = heap_i_q[AddrW-1:0]; state_d = StPrefixWr;
        end
      end
      StPrefixWr: begin
        acc_d = acc_q + SumW'(v_rd);
        p_we = 1'b1; p_addr = heap_i_q[AddrW-1:0]; p_wd = acc_q + SumW'(v_rd);
        heap_i_d = heap_i_q + 1'b1; state_d = StPrefix;
      end
      StSearch: begin
        if (lo_q < hi_q) begin
          v_addr = mid[AddrW-1:0]; state_d = StSearchCmp;
        end else if (!second_q) begin
          start_d = lo_q; lo_d = '0; hi_d = count_q; second_d = 1'b1;
        end else begin
          end_d = lo_q; state_d = StSumRd;
        end
      end
      StSearchCmp: begin
        if (!second_q ? (v_rd > lb_q) : !(v_rd < ub_q)) hi_d = mid;
        else lo_d = mid + 1'b1;
        state_d = StSearch;
      end
      StSumRd: begin
        // read prefix at start-1, then end-1
        p_addr = AddrW'(start_q - 1'b1); state_d = StSumWait; sub_d = '0;
      end
      StSumWait: begin
        // hold the end-1 address so its word is on p_rd in StOut
        p_addr = AddrW'(end_q - 1'b1);
        if (sub_q == '0) begin
          psa_d = (start_q == '0) ? '0 : p_rd;
          sub_d = 2'd1;
        end else state_d = StOut;
      end
      StOut: begin
        rsp_d.load_dropped = ovf_q;
        if (end_q > start_q) begin
          rsp_d.match_count = OutCntW'(end_q - start_q);
          rsp_d.range_sum = p_rd - psa_q;
        end else begin
          rsp_d.match_count = '0; rsp_d.range_sum = '0;
        end
        rsp_v_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; sorted_q <= 1'b0; ovf_q <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; sorted_q <= sorted_d;
      ovf_q <= ovf_d; rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    heap_i_q <= heap_i_d; len_q <= len_d; root_q <= root_d; big_q <= big_d;
    sub_q <= sub_d; build_q <= build_d; rootv_q <= rootv_d; bigv_q <= bigv_d;
    acc_q <= acc_d; lo_q <= lo_d; hi_q <= hi_d; start_q <= start_d;
    second_q <= second_d; lb_q <= lb_d; ub_q <= ub_d; psa_q <= psa_d;
    end_q <= end_d; rsp_q <= rsp_d;
  end

  `include "sorted_open_interval_range_sum_macros.svh"
  `SOIRS_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, count_q <= CntW'(MaxEntries), "count over max")
  `SOIRS_ASSERT_IMP(a_rsp_idle, clk_i, rst_ni, rsp_v_q, state_q == StIdle, "result while busy")
  `SOIRS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_v_q && !rsp_if.ready, $stable(rsp_q), "result moved")
endmodule
